[rtl/tapr_pkg.sv]
// Shared types and constants for the TCP address and port rewriter.
// Used by the front classifier, the beat queue, the back emitter and the top level.
package tapr_pkg;

    localparam int HEADER_BEATS = 10;
    localparam int HB_W = $clog2(HEADER_BEATS + 1);
    localparam int IDX_W = $clog2(HEADER_BEATS);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETHER_HEADER_BYTES = 16'd14;
    localparam logic [15:0] MIN_HEADER_BYTES = 16'd20;
    localparam logic [7:0] PROTOCOL_TCP = 8'd6;

    localparam logic [1:0] REG_MATCH_ADDRESS = 2'd0;
    localparam logic [1:0] REG_MATCH_PORT = 2'd1;
    localparam logic [1:0] REG_NEW_ADDRESS = 2'd2;
    localparam logic [1:0] REG_NEW_PORT = 2'd3;

    typedef enum logic [1:0] {
        VERDICT_WAIT,
        VERDICT_PASS,
        VERDICT_DROP,
        VERDICT_REWRITE
    } verdict_t;

    // Command handed from the front to the back through the queue.
    typedef enum logic [1:0] {
        CMD_FLUSH,
        CMD_FORWARD,
        CMD_MARKER
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic             rewrite_src;
        logic             rewrite_dst;
        logic [3:0]       header_words;
        logic [HB_W-1:0]  beat_count;
        logic [63:0]      data;
        logic [3:0]       bytes;
        logic             frame_end;
    } cmd_t;

    typedef struct packed {
        logic [31:0] match_address;
        logic [15:0] match_port;
        logic [31:0] new_address;
        logic [15:0] new_port;
    } cfg_t;

    // Byte k of the frame, from a flat store of beats.
    function automatic logic [7:0] store_byte(
        input logic [HEADER_BEATS*64-1:0] flat, input logic [7:0] k);
        logic [IDX_W+3:0] beat;
        beat = {{(IDX_W + 4 - 5){1'b0}}, k[7:3]};
        store_byte = 8'h00;
        if (beat < (IDX_W + 4)'(HEADER_BEATS)) begin
            store_byte = flat[(HEADER_BEATS - 1 - int'(beat)) * 64
                              + (7 - int'(k[2:0])) * 8 +: 8];
        end
    endfunction

endpackage

[rtl/tapr_front.sv]
// Front part: collects header beats, classifies each frame and issues commands.
// Depends on tapr_pkg; its commands feed tapr_queue.
module tapr_front
    import tapr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_beat_data,
    input  logic [3:0]  s_beat_bytes,
    input  logic        s_frame_end,
    input  logic [15:0] s_captured_length,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd,
    output logic [HEADER_BEATS*64-1:0] store_flat
);

    logic [63:0]     store_reg [HEADER_BEATS];
    logic [HB_W-1:0] stored_reg, stored_next;
    logic            forward_reg, forward_next;
    logic            halted_reg, halted_next;
    logic [3:0]      cnt;
    logic [HB_W-1:0] slot;
    logic [HB_W-1:0] beats_now;
    logic [15:0]     have;
    logic [HEADER_BEATS*64-1:0] view;
    logic [15:0]     kind;
    logic [7:0]      ihl_byte;
    logic [3:0]      ihl;
    logic [15:0]     total;
    logic [7:0]      proto;
    logic [15:0]     tcp_off;
    verdict_t        verdict, final_verdict;
    logic            src_hit, dst_hit;
    logic            accept;

    assign cnt = (s_beat_bytes > 4'd8) ? 4'd8 : s_beat_bytes;
    assign slot = (stored_reg >= HB_W'(HEADER_BEATS)) ? HB_W'(HEADER_BEATS - 1) : stored_reg;
    assign beats_now = slot + HB_W'(1);
    assign have = 16'({slot, 3'b000}) + 16'(cnt);

    // Store view including the beat now arriving.
    always_comb begin
        for (int i = 0; i < HEADER_BEATS; i++) begin
            view[(HEADER_BEATS - 1 - i) * 64 +: 64] =
                (HB_W'(i) == slot) ? s_beat_data : store_reg[i];
        end
    end
    assign store_flat = view;

    assign kind = {store_byte(view, 8'd12), store_byte(view, 8'd13)};
    assign ihl_byte = store_byte(view, 8'd14);
    assign ihl = ihl_byte[3:0];
    assign total = {store_byte(view, 8'd16), store_byte(view, 8'd17)};
    assign proto = store_byte(view, 8'd23);
    assign tcp_off = ETHER_HEADER_BYTES + 16'({ihl, 2'b00});

    // Classification, in priority order.
    always_comb begin
        if (s_captured_length < ETHER_HEADER_BYTES) verdict = VERDICT_PASS;
        else if (have < 16'd14) verdict = VERDICT_WAIT;
        else if (kind != ETHERTYPE_IPV4) verdict = VERDICT_PASS;
        else if (s_captured_length < 16'd34) verdict = VERDICT_DROP;
        else if (have < 16'd18) verdict = VERDICT_WAIT;
        else if (total > s_captured_length) verdict = VERDICT_DROP;
        else if (have < 16'd24) verdict = VERDICT_WAIT;
        else if (proto != PROTOCOL_TCP) verdict = VERDICT_PASS;
        else if (ihl < 4'd5) verdict = VERDICT_PASS;
        else if (total < tcp_off + MIN_HEADER_BYTES - ETHER_HEADER_BYTES) verdict = VERDICT_DROP;
        else if (have < tcp_off + 16'd4) verdict = VERDICT_WAIT;
        else verdict = VERDICT_REWRITE;
        final_verdict = verdict;
        if (verdict == VERDICT_WAIT &&
            (s_frame_end || cnt < 4'd8 || beats_now >= HB_W'(HEADER_BEATS))) begin
            final_verdict = VERDICT_PASS;
        end
    end

    // Match tests on the address and port pairs.
    always_comb begin
        logic [31:0] sa, da;
        logic [15:0] sp, dp;
        logic [7:0]  t;
        t = tcp_off[7:0];
        sa = {store_byte(view, 8'd26), store_byte(view, 8'd27),
              store_byte(view, 8'd28), store_byte(view, 8'd29)};
        da = {store_byte(view, 8'd30), store_byte(view, 8'd31),
              store_byte(view, 8'd32), store_byte(view, 8'd33)};
        sp = {store_byte(view, t), store_byte(view, t + 8'd1)};
        dp = {store_byte(view, t + 8'd2), store_byte(view, t + 8'd3)};
        src_hit = (sa == cfg.match_address) && (sp == cfg.match_port);
        dst_hit = (da == cfg.match_address) && (dp == cfg.match_port);
    end

    // Command generation and handshake.
    always_comb begin
        cmd = '0;
        cmd.kind = CMD_FORWARD;
        cmd.header_words = ihl;
        cmd.beat_count = beats_now;
        cmd.data = s_beat_data;
        cmd.bytes = cnt;
        cmd.frame_end = s_frame_end;
        cmd_valid = 1'b0;
        if (!halted_reg && s_valid) begin
            if (forward_reg) begin
                cmd_valid = 1'b1;
            end else if (final_verdict == VERDICT_DROP) begin
                cmd_valid = 1'b1;
                cmd.kind = CMD_MARKER;
            end else if (final_verdict != VERDICT_WAIT) begin
                cmd_valid = 1'b1;
                cmd.kind = CMD_FLUSH;
                cmd.rewrite_src = (final_verdict == VERDICT_REWRITE) && src_hit;
                cmd.rewrite_dst = (final_verdict == VERDICT_REWRITE) && dst_hit;
            end
        end
        s_ready = halted_reg || !cmd_valid || cmd_ready;
        // Waiting for the back to drain before a flush overwrites the store.
        if (!halted_reg && !forward_reg && cmd_valid && cmd.kind == CMD_FLUSH) begin
            s_ready = cmd_ready;
        end
    end

    assign accept = s_valid && s_ready;

    always_comb begin
        stored_next = stored_reg;
        forward_next = forward_reg;
        halted_next = halted_reg;
        if (accept && !halted_reg) begin
            if (forward_reg) begin
                if (s_frame_end) forward_next = 1'b0;
            end else if (final_verdict == VERDICT_WAIT) begin
                stored_next = beats_now;
            end else if (final_verdict == VERDICT_DROP) begin
                halted_next = 1'b1;
                stored_next = '0;
            end else begin
                stored_next = '0;
                forward_next = !s_frame_end;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stored_reg <= '0;
            forward_reg <= 1'b0;
            halted_reg <= 1'b0;
        end else begin
            stored_reg <= stored_next;
            forward_reg <= forward_next;
            halted_reg <= halted_next;
        end
    end

    // Header store write.
    always_ff @(posedge aclk) begin
        if (accept && !halted_reg && !forward_reg) begin
            store_reg[slot[IDX_W-1:0]] <= s_beat_data;
        end
    end

endmodule

[rtl/tapr_queue.sv]
// Short command queue between the front and the back parts.
// Depends on tapr_pkg for the command type.
module tapr_queue
    import tapr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    input  logic [HEADER_BEATS*64-1:0] in_store,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd,
    output logic [HEADER_BEATS*64-1:0] out_store
);

    cmd_t              mem [QUEUE_DEPTH];
    logic [HEADER_BEATS*64-1:0] store_reg;
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QPTR_W:0]   count_reg;
    logic              push, pop;

    // A flush snapshot is held until that flush leaves; only one flush may be queued.
    logic              flush_held_reg;
    logic              is_flush;
    assign is_flush = (in_cmd.kind == CMD_FLUSH);
    assign in_ready = (count_reg < (QPTR_W + 1)'(QUEUE_DEPTH)) && !(is_flush && flush_held_reg);
    assign out_valid = (count_reg != '0);
    assign out_cmd = mem[rd_reg];
    assign out_store = store_reg;
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            count_reg <= '0;
            flush_held_reg <= 1'b0;
        end else begin
            if (push) wr_reg <= wr_reg + QPTR_W'(1);
            if (pop) rd_reg <= rd_reg + QPTR_W'(1);
            count_reg <= count_reg + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
            if (push && is_flush) flush_held_reg <= 1'b1;
            else if (pop && out_cmd.kind == CMD_FLUSH) flush_held_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= in_cmd;
            if (is_flush) store_reg <= in_store;
        end
    end

endmodule

[rtl/tapr_back.sv]
// Back part: emits flushed header beats with rewrites, forwarded beats and markers.
// Depends on tapr_pkg; takes commands from tapr_queue.
module tapr_back
    import tapr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    input  logic [HEADER_BEATS*64-1:0] store_flat,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_out_data,
    output logic [3:0]  m_out_bytes,
    output logic        m_out_end,
    output logic        m_out_status
);

    logic [HB_W-1:0] idx_reg, idx_next;
    logic            out_valid_reg;
    logic [63:0]     data_reg;
    logic [3:0]      bytes_reg;
    logic            end_reg, status_reg;
    logic            load;
    logic            last;
    logic [63:0]     beat;
    logic [63:0]     patched;
    logic [7:0]      tcp;

    assign m_valid = out_valid_reg;
    assign m_out_data = data_reg;
    assign m_out_bytes = bytes_reg;
    assign m_out_end = end_reg;
    assign m_out_status = status_reg;

    assign load = cmd_valid && (!out_valid_reg || m_ready);
    assign last = (cmd.kind != CMD_FLUSH) || (idx_reg + HB_W'(1) == cmd.beat_count);
    assign cmd_ready = load && last;
    assign tcp = 8'd14 + {2'b00, cmd.header_words, 2'b00};

    // Beat of the store at the current index, with rewritten bytes patched in.
    always_comb begin
        logic [7:0] k;
        beat = store_flat[(HEADER_BEATS - 1 - int'(idx_reg)) * 64 +: 64];
        patched = beat;
        for (int b = 0; b < 8; b++) begin
            k = 8'({idx_reg, 3'(b)});
            if (cmd.rewrite_src) begin
                if (k >= 8'd26 && k <= 8'd29)
                    patched[(7 - b) * 8 +: 8] = cfg.new_address[(29 - int'(k)) * 8 +: 8];
                if (k == tcp) patched[(7 - b) * 8 +: 8] = cfg.new_port[15:8];
                if (k == tcp + 8'd1) patched[(7 - b) * 8 +: 8] = cfg.new_port[7:0];
            end
            if (cmd.rewrite_dst) begin
                if (k >= 8'd30 && k <= 8'd33)
                    patched[(7 - b) * 8 +: 8] = cfg.new_address[(33 - int'(k)) * 8 +: 8];
                if (k == tcp + 8'd2) patched[(7 - b) * 8 +: 8] = cfg.new_port[15:8];
                if (k == tcp + 8'd3) patched[(7 - b) * 8 +: 8] = cfg.new_port[7:0];
            end
        end
    end

    always_comb begin
        idx_next = idx_reg;
        if (load && cmd.kind == CMD_FLUSH) begin
            idx_next = last ? '0 : idx_reg + HB_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            if (load) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (load) begin
            case (cmd.kind)
                CMD_FLUSH: begin
                    data_reg <= patched;
                    bytes_reg <= last ? cmd.bytes : 4'd8;
                    end_reg <= last ? cmd.frame_end : 1'b0;
                    status_reg <= 1'b0;
                end
                CMD_MARKER: begin
                    data_reg <= '0;
                    bytes_reg <= '0;
                    end_reg <= 1'b0;
                    status_reg <= 1'b1;
                end
                default: begin
                    data_reg <= cmd.data;
                    bytes_reg <= cmd.bytes;
                    end_reg <= cmd.frame_end;
                    status_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule

[rtl/tcp_address_port_rewriter.sv]
// Top level of the TCP address and port rewriter (static NAT on IPv4/TCP).
// Depends on tapr_pkg, tapr_front, tapr_queue and tapr_back.
//
//   channel   ports                                  role
//   s_        s_valid/s_ready, beat fields           frame beats in
//   m_        m_valid/m_ready, out fields            beats and markers out
//   cfg       cfg_write_enable, cfg_index, cfg_data  register writes
//
// Header beats are buffered one per cycle; at the decision the stored beats leave one
// per cycle while the output is not stalled, sent out by the emitter.
// After the decision an accepted beat reaches the output through the queue and the output
// register, and beats follow at one per cycle while the output is not stalled.
// Reset is synchronous and active low; it clears all control state and the halt.
// Either side may stall; the queue lets the front keep accepting while output waits.
module tcp_address_port_rewriter
    import tapr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_write_enable,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_beat_data,
    input  logic [3:0]  s_beat_bytes,
    input  logic        s_frame_end,
    input  logic [15:0] s_captured_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_out_data,
    output logic [3:0]  m_out_bytes,
    output logic        m_out_end,
    output logic        m_out_status
);

    cfg_t cfg_reg;
    logic f_valid, f_ready, b_valid, b_ready;
    cmd_t f_cmd, b_cmd;
    logic [HEADER_BEATS*64-1:0] f_store, b_store;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_write_enable) begin
            unique case (cfg_index)
                REG_MATCH_ADDRESS: cfg_reg.match_address <= cfg_data;
                REG_MATCH_PORT:    cfg_reg.match_port <= cfg_data[15:0];
                REG_NEW_ADDRESS:   cfg_reg.new_address <= cfg_data;
                REG_NEW_PORT:      cfg_reg.new_port <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    tapr_front u_front (
        .aclk, .aresetn, .cfg(cfg_reg),
        .s_valid, .s_ready, .s_beat_data, .s_beat_bytes, .s_frame_end, .s_captured_length,
        .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd), .store_flat(f_store)
    );

    tapr_queue u_queue (
        .aclk, .aresetn,
        .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd), .in_store(f_store),
        .out_valid(b_valid), .out_ready(b_ready), .out_cmd(b_cmd), .out_store(b_store)
    );

    tapr_back u_back (
        .aclk, .aresetn, .cfg(cfg_reg),
        .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd), .store_flat(b_store),
        .m_valid, .m_ready, .m_out_data, .m_out_bytes, .m_out_end, .m_out_status
    );

endmodule

[verif/tcp_address_port_rewriter_tb.sv]
// Self-checking testbench for the TCP address and port rewriter.
// Depends on tapr_pkg and tcp_address_port_rewriter; predicts every output beat in place.
module tcp_address_port_rewriter_tb;
    import tapr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_BEATS = 200;

    typedef struct {
        logic [63:0] data;
        logic [3:0]  bytes;
        logic        last;
        logic        status;
    } out_beat_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_write_enable;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_beat_data;
    logic [3:0]  s_beat_bytes;
    logic        s_frame_end;
    logic [15:0] s_captured_length;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_out_data;
    logic [3:0]  m_out_bytes;
    logic        m_out_end;
    logic        m_out_status;

    tcp_address_port_rewriter uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_write_enable(cfg_write_enable), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_beat_data(s_beat_data),
        .s_beat_bytes(s_beat_bytes), .s_frame_end(s_frame_end),
        .s_captured_length(s_captured_length),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_data(m_out_data),
        .m_out_bytes(m_out_bytes), .m_out_end(m_out_end), .m_out_status(m_out_status)
    );

    // Predictor state: a private copy of registers and frame tracking.
    logic [31:0] nat_match_addr, nat_new_addr;
    logic [15:0] nat_match_port, nat_new_port;
    logic [63:0] hdr_beats [HEADER_BEATS];
    int          hdr_count;
    int          hdr_bytes;
    logic        forwarding;
    logic        halted;
    int          ihl_words;
    int          total_len;

    out_beat_t   expected_beats[$];
    logic [7:0]  frame_bytes[$];
    int          mismatches;
    int          beats_sent;
    int          beats_seen;
    int          cycles;
    bit          no_idle;

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Frame byte k of the header store.
    function automatic logic [7:0] hdr_byte(input int k);
        if ((k >> 3) >= HEADER_BEATS) return 8'h00;
        return hdr_beats[k >> 3][(7 - (k & 7)) * 8 +: 8];
    endfunction

    function automatic int hdr_field(input int k, input int n);
        int v;
        v = 0;
        for (int i = 0; i < n; i++) v = (v << 8) | hdr_byte(k + i);
        return v;
    endfunction

    task automatic hdr_put(input int k, input int n, input logic [31:0] v);
        for (int i = 0; i < n; i++) begin
            if (((k + i) >> 3) < HEADER_BEATS)
                hdr_beats[(k + i) >> 3][(7 - ((k + i) & 7)) * 8 +: 8] =
                    v[(n - 1 - i) * 8 +: 8];
        end
    endtask

    // Classify the frame from what has been buffered so far.
    function automatic verdict_t classify(input int cap);
        int tcp_off;
        if (cap < ETHER_HEADER_BYTES) return VERDICT_PASS;
        if (hdr_bytes < 14) return VERDICT_WAIT;
        if (hdr_field(12, 2) != ETHERTYPE_IPV4) return VERDICT_PASS;
        if (cap < ETHER_HEADER_BYTES + MIN_HEADER_BYTES) return VERDICT_DROP;
        if (hdr_bytes < 18) return VERDICT_WAIT;
        ihl_words = hdr_byte(14) & 4'hF;
        total_len = hdr_field(16, 2);
        if (total_len > cap) return VERDICT_DROP;
        if (hdr_bytes < 24) return VERDICT_WAIT;
        if (hdr_byte(23) != PROTOCOL_TCP) return VERDICT_PASS;
        if (ihl_words < 5) return VERDICT_PASS;
        if (total_len < ihl_words * 4 + MIN_HEADER_BYTES) return VERDICT_DROP;
        tcp_off = ETHER_HEADER_BYTES + ihl_words * 4;
        if (hdr_bytes < tcp_off + 4) return VERDICT_WAIT;
        return VERDICT_REWRITE;
    endfunction

    task automatic nat_rewrite();
        int tcp_off;
        tcp_off = ETHER_HEADER_BYTES + ihl_words * 4;
        if (hdr_field(26, 4) == nat_match_addr && hdr_field(tcp_off, 2) == nat_match_port) begin
            hdr_put(26, 4, nat_new_addr);
            hdr_put(tcp_off, 2, nat_new_port);
        end
        if (hdr_field(30, 4) == nat_match_addr
            && hdr_field(tcp_off + 2, 2) == nat_match_port) begin
            hdr_put(30, 4, nat_new_addr);
            hdr_put(tcp_off + 2, 2, nat_new_port);
        end
    endtask

    // Work out the output beats caused by one accepted input beat.
    task automatic predict_beat(input logic [63:0] d, input logic [3:0] n, input logic e,
                                input logic [15:0] cap);
        int cnt;
        verdict_t v;
        out_beat_t ob;
        if (halted) return;
        cnt = (n > 8) ? 8 : n;
        if (forwarding) begin
            ob = '{d, 4'(cnt), e, 1'b0};
            expected_beats.push_back(ob);
            if (e) forwarding = 1'b0;
            return;
        end
        if (hdr_count >= HEADER_BEATS) hdr_count = HEADER_BEATS - 1;
        hdr_beats[hdr_count] = d;
        hdr_count++;
        hdr_bytes = (hdr_count - 1) * 8 + cnt;
        v = classify(cap);
        if (v == VERDICT_WAIT && (e || cnt < 8 || hdr_count >= HEADER_BEATS))
            v = VERDICT_PASS;
        if (v == VERDICT_WAIT) return;
        if (v == VERDICT_DROP) begin
            halted = 1'b1;
            hdr_count = 0;
            hdr_bytes = 0;
            ob = '{64'd0, 4'd0, 1'b0, 1'b1};
            expected_beats.push_back(ob);
            return;
        end
        if (v == VERDICT_REWRITE) nat_rewrite();
        for (int i = 0; i < hdr_count; i++) begin
            ob.data = hdr_beats[i];
            ob.bytes = (i + 1 == hdr_count) ? 4'(cnt) : 4'd8;
            ob.last = (i + 1 == hdr_count) ? e : 1'b0;
            ob.status = 1'b0;
            expected_beats.push_back(ob);
        end
        hdr_count = 0;
        hdr_bytes = 0;
        forwarding = !e;
    endtask

    // Gap before a beat: mostly none, sometimes short, rarely long.
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Send one beat and hold it until the block takes it.
    task automatic send_beat(input logic [63:0] d, input logic [3:0] n, input logic e,
                             input logic [15:0] cap);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_beat_data <= d;
        s_beat_bytes <= n;
        s_frame_end <= e;
        s_captured_length <= cap;
        do @(posedge aclk); while (!s_ready);
        predict_beat(d, n, e, cap);
        beats_sent++;
    endtask

    // Send frame_bytes as beats; short_beat forces a partial beat before the end,
    // odd_counts puts out-of-range byte counts on full beats.
    task automatic send_frame(input int cap, input int short_beat, input bit odd_counts);
        int nbeats;
        int valid_bytes;
        logic [63:0] d;
        logic [3:0] n;
        nbeats = (frame_bytes.size() + 7) / 8;
        if (nbeats == 0) nbeats = 1;
        for (int b = 0; b < nbeats; b++) begin
            d = {$urandom, $urandom};
            valid_bytes = 0;
            for (int k = 0; k < 8; k++) begin
                if (b * 8 + k < frame_bytes.size()) begin
                    d[(7 - k) * 8 +: 8] = frame_bytes[b * 8 + k];
                    valid_bytes++;
                end
            end
            n = (valid_bytes == 0) ? 4'd1 : 4'(valid_bytes);
            if (b == short_beat && b + 1 < nbeats) n = 4'($urandom_range(0, 7));
            else if (odd_counts && n == 8 && $urandom_range(0, 2) == 0)
                n = 4'($urandom_range(9, 15));
            send_beat(d, n, b + 1 == nbeats, 16'(cap));
        end
    endtask

    // Fill frame_bytes with a TCP/IPv4 frame of len bytes.
    task automatic build_tcp(input int len, input int ihl, input int total,
                             input logic [31:0] src, input logic [15:0] sport,
                             input logic [31:0] dst, input logic [15:0] dport);
        int t;
        frame_bytes.delete();
        for (int i = 0; i < len; i++) frame_bytes.push_back(8'($urandom));
        t = 14 + ihl * 4;
        for (int i = 0; i < len; i++) begin
            case (i)
                12: frame_bytes[i] = 8'h08;
                13: frame_bytes[i] = 8'h00;
                14: frame_bytes[i] = {4'h4, 4'(ihl)};
                16: frame_bytes[i] = 8'(total >> 8);
                17: frame_bytes[i] = 8'(total);
                23: frame_bytes[i] = PROTOCOL_TCP;
                default: ;
            endcase
            if (i >= 26 && i < 30) frame_bytes[i] = src[(29 - i) * 8 +: 8];
            if (i >= 30 && i < 34) frame_bytes[i] = dst[(33 - i) * 8 +: 8];
            if (i == t) frame_bytes[i] = sport[15:8];
            if (i == t + 1) frame_bytes[i] = sport[7:0];
            if (i == t + 2) frame_bytes[i] = dport[15:8];
            if (i == t + 3) frame_bytes[i] = dport[7:0];
        end
    endtask

    // A well-formed TCP frame whose endpoints match the registers at random.
    task automatic send_tcp_frame(input int len, input int ihl);
        logic [31:0] src, dst;
        logic [15:0] sport, dport;
        int total;
        if (ihl * 4 + 20 > len) ihl = (len - 20) / 4;
        src = $urandom_range(0, 1) ? nat_match_addr : $urandom;
        dst = $urandom_range(0, 1) ? nat_match_addr : $urandom;
        sport = $urandom_range(0, 2) != 0 ? nat_match_port : 16'($urandom);
        dport = $urandom_range(0, 2) != 0 ? nat_match_port : 16'($urandom);
        total = $urandom_range(ihl * 4 + 20, len);
        build_tcp(len, ihl, total, src, sport, dst, dport);
        send_frame(len + $urandom_range(0, 3), -1, 1'b0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge aclk);
        s_valid <= 1'b0;
        cfg_write_enable <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_MATCH_ADDRESS: nat_match_addr = value;
            REG_MATCH_PORT:    nat_match_port = value[15:0];
            REG_NEW_ADDRESS:   nat_new_addr = value;
            REG_NEW_PORT:      nat_new_port = value[15:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_write_enable <= 1'b0;
    endtask

    task automatic set_nat(input logic [31:0] ma, input logic [15:0] mp,
                           input logic [31:0] na, input logic [15:0] np);
        write_reg(REG_MATCH_ADDRESS, ma);
        write_reg(REG_MATCH_PORT, {16'd0, mp});
        write_reg(REG_NEW_ADDRESS, na);
        write_reg(REG_NEW_PORT, {16'd0, np});
    endtask

    // Let the block drain, plus time for a frame still held in the header store.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_beats.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    // Frames that pass unchanged, plus the odd corner cases of beat counts.
    task automatic test_pass_through();
        // Capture too short to hold an Ethernet header.
        build_tcp(20, 5, 20, 0, 0, 0, 0);
        send_frame(13, -1, 1'b0);
        // Not IPv4.
        build_tcp(24, 5, 40, 0, 0, 0, 0);
        frame_bytes[12] = 8'h86;
        frame_bytes[13] = 8'hDD;
        send_frame(16'hFFFF, -1, 1'b0);
        // IPv4 but not TCP.
        build_tcp(40, 5, 40, 0, 0, 0, 0);
        frame_bytes[23] = 8'd17;
        send_frame(40, -1, 1'b0);
        // Header length under five words.
        build_tcp(40, 3, 40, 0, 0, 0, 0);
        send_frame(40, -1, 1'b0);
        // Frame ends before the ports are in.
        build_tcp(30, 5, 40, 0, 0, 0, 0);
        send_frame(60, -1, 1'b0);
        // Partial beat before a decision, then a lone frame beat with a zero count.
        build_tcp(48, 5, 40, 0, 0, 0, 0);
        send_frame(48, 1, 1'b0);
        send_beat({$urandom, $urandom}, 4'd0, 1'b1, 16'd48);
        wait_drained();
    endtask

    // Directed rewrites of the source, the destination, both and neither.
    task automatic test_rewrite_directed();
        set_nat(32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0000, 16'h0000);
        build_tcp(54, 5, 40, 32'hFFFF_FFFF, 16'hFFFF, 32'h0A00_0001, 16'd80);
        send_frame(54, -1, 1'b0);
        build_tcp(80, 15, 80, 32'h0A00_0001, 16'd80, 32'hFFFF_FFFF, 16'hFFFF);
        send_frame(80, -1, 1'b0);
        wait_drained();
        set_nat(32'hC0A8_0101, 16'd443, 32'hFFFF_FFFF, 16'hFFFF);
        build_tcp(60, 6, 44, 32'hC0A8_0101, 16'd443, 32'hC0A8_0101, 16'd443);
        send_frame(60, -1, 1'b0);
        build_tcp(60, 5, 40, 32'hC0A8_0101, 16'd444, 32'hC0A8_0102, 16'd443);
        send_frame(60, -1, 1'b0);
        wait_drained();
    endtask

    // Random frames across several register settings.
    task automatic test_random_traffic();
        int r, len, stop_at;
        for (int phase = 0; phase < 4; phase++) begin
            if (phase == 0) set_nat(32'h0, 16'h0, 32'h0, 16'h0);
            else set_nat($urandom, 16'($urandom), $urandom, 16'($urandom));
            no_idle = (phase == 2);
            stop_at = beats_sent + RANDOM_BEATS / 4;
            while (beats_sent < stop_at) begin
                r = $urandom_range(0, 99);
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                  : $urandom_range(54, 100);
                if (r < 65) begin
                    send_tcp_frame(len, $urandom_range(0, 4) == 0 ? $urandom_range(6, 15) : 5);
                end else if (r < 72) begin
                    build_tcp(len, 5, 40, 0, 0, 0, 0);
                    frame_bytes[12] = 8'($urandom_range(0, 7));
                    send_frame($urandom_range(0, 65535), -1, 1'b1);
                end else if (r < 78) begin
                    build_tcp(len, 5, 40, nat_match_addr, nat_match_port, 0, 0);
                    frame_bytes[23] = 8'($urandom_range(7, 255));
                    send_frame(len, -1, 1'b1);
                end else if (r < 83) begin
                    build_tcp(len, $urandom_range(0, 4), 40, nat_match_addr,
                              nat_match_port, 0, 0);
                    send_frame(len, -1, 1'b0);
                end else if (r < 88) begin
                    build_tcp($urandom_range(1, 40), 5, 40, 0, 0, 0, 0);
                    send_frame($urandom_range(0, 13), -1, 1'b1);
                end else if (r < 94) begin
                    build_tcp($urandom_range(1, 37), 5, 40, nat_match_addr,
                              nat_match_port, 0, 0);
                    send_frame(60, -1, 1'b0);
                end else begin
                    build_tcp(len, 5, 40, nat_match_addr, nat_match_port, 0, 0);
                    send_frame(len, $urandom_range(0, 3), 1'b1);
                end
            end
            wait_drained();
        end
        no_idle = 1'b0;
    endtask

    // One malformed frame halts the block; later input must vanish.
    task automatic test_drop_and_halt();
        int kind;
        kind = $urandom_range(0, 2);
        if (kind == 0) begin
            build_tcp(40, 5, 30, 0, 0, 0, 0);
            send_frame($urandom_range(14, 33), -1, 1'b0);
        end else if (kind == 1) begin
            build_tcp(60, 5, 61, 0, 0, 0, 0);
            send_frame(60, -1, 1'b0);
        end else begin
            build_tcp(60, 8, 40, 0, 0, 0, 0);
            send_frame(60, -1, 1'b0);
        end
        for (int i = 0; i < 2; i++) send_tcp_frame(60, 5);
        wait_drained();
    endtask

    // Output side: random stalls, mostly short.
    int stall_left;
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 99) < 25) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                      : $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare each output beat with the oldest expected one.
    always @(posedge aclk) begin
        out_beat_t ob;
        if (aresetn && m_valid && m_ready) begin
            beats_seen++;
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: data %h bytes %0d end %b status %b",
                             m_out_data, m_out_bytes, m_out_end, m_out_status);
            end else begin
                ob = expected_beats.pop_front();
                if (m_out_data !== ob.data || m_out_bytes !== ob.bytes
                    || m_out_end !== ob.last || m_out_status !== ob.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h/%0d/%b/%b got %h/%0d/%b/%b",
                                 ob.data, ob.bytes, ob.last, ob.status, m_out_data,
                                 m_out_bytes, m_out_end, m_out_status);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_index = REG_MATCH_ADDRESS;
        cfg_data = 32'd0;
        s_valid = 1'b0;
        s_beat_data = 64'd0;
        s_beat_bytes = 4'd8;
        s_frame_end = 1'b0;
        s_captured_length = 16'd0;
        m_ready = 1'b0;
        stall_left = 0;
        cycles = 0;
        mismatches = 0;
        beats_sent = 0;
        beats_seen = 0;
        no_idle = 1'b0;
        nat_match_addr = 0;
        nat_match_port = 0;
        nat_new_addr = 0;
        nat_new_port = 0;
        hdr_count = 0;
        hdr_bytes = 0;
        forwarding = 1'b0;
        halted = 1'b0;
        ihl_words = 0;
        total_len = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        repeat (50) @(negedge aclk);

        test_pass_through();
        test_rewrite_directed();
        test_random_traffic();
        test_drop_and_halt();

        if (expected_beats.size() != 0) begin
            mismatches++;
            $display("%0d expected beats never arrived", expected_beats.size());
        end
        $display("covered pass-through, rewrite, flush and halt paths: %0d beats in, %0d out",
                 beats_sent, beats_seen);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
